### hw/rtl/hash_set_dedup_filter_defines.svh
// Assertion macros for the hash set dedup filter checker.
// Used by files that carry concurrent assertions; expects clk and rst in scope.
`ifndef HASH_SET_DEDUP_FILTER_DEFINES_SVH
`define HASH_SET_DEDUP_FILTER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define HSDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define HSDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hsdf_pkg.sv
// Shared constants, types and codes for the hash set dedup filter.
// No dependencies; every RTL source but the assertion macros header refers to it by scoped names.
`default_nettype none

package hsdf_pkg;

  // Table geometry and probe bound
  localparam int TABLE_SLOTS   = 65536;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int PROBE_LIMIT   = 4096;
  localparam int PROBE_CNT_W   = $clog2(PROBE_LIMIT + 1);

  // Field widths
  localparam int KEY_W         = 64;
  localparam int UNIQUE_W      = 17;
  localparam int OVERFLOW_W    = 32;
  localparam int INDEX_BITS_W  = 5;

  // Configuration port
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_REPEATED = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS      = 1'b1;
  localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RESET   = 5'd16;
  localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_MIN     = 5'd4;

  // Queue between classifier and prober (power of two)
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OUT_NEW = 2'd0,
    OUT_DUP = 2'd1,
    OUT_OVF = 2'd2
  } outcome_t;

  // One classified item waiting for the prober
  typedef struct packed {
    logic [KEY_W-1:0]  key_hash;
    logic [SLOT_W-1:0] start_idx;
    logic [SLOT_W-1:0] mask;
    logic              report_repeated;
  } entry_t;

  // Prober status seen by the front
  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/hsdf_if.sv
// Valid/ready channel interfaces for the hash set dedup filter.
// Depends on hsdf_pkg for field widths.
`default_nettype none

interface hsdf_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsdf_pkg::KEY_W-1:0]    key_hash;

  modport source (output valid, output key_hash, input ready);
  modport sink   (input valid, input key_hash, output ready);
endinterface

interface hsdf_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        outcome;
  logic                              emit;
  logic [hsdf_pkg::UNIQUE_W-1:0]     unique_total;
  logic [hsdf_pkg::OVERFLOW_W-1:0]   overflow_total;

  modport source (output valid, output outcome, output emit, output unique_total,
                  output overflow_total, input ready);
  modport sink   (input valid, input outcome, input emit, input unique_total,
                  input overflow_total, output ready);
endinterface

`default_nettype wire

### hw/rtl/hash_set_dedup_filter.sv
// Top level of the hash set dedup filter: front, queue and prober wired together.
// Depends on hsdf_pkg, hsdf_if, hsdf_front, hsdf_queue and hsdf_probe.
`default_nettype none

// Duplicate filter over 64-bit line hashes. Each transfer on items is looked up
// in a 65536-slot open-addressed table by linear probing from the hash's low
// index bits (index_bits, 4..16) and yields one transfer on results: new
// (stored), duplicate, or overflow after 4096 probed slots, with the emit flag
// and running counters. Each further slot probed lengthens an item's handling,
// since the single table read port returns registered data one slot per cycle.
// A two-entry queue lets the front accept items while the prober works and
// while a result waits. After reset the table is cleared one slot per cycle
// with items.ready low; configuration writes are taken throughout, and the user
// must write them only while idle: the block itself does not enforce it.
module hash_set_dedup_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  hsdf_in_if.sink                                items,
  hsdf_out_if.source                             results,
  input  wire logic                              cfg_we,
  input  wire logic [hsdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hsdf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hsdf_pkg::status_t  status;
  hsdf_pkg::entry_t   push_entry;
  hsdf_pkg::entry_t   q_entry;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;

  // Accept and classify
  hsdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .q_full    (q_full),
    .push      (push),
    .entry     (push_entry)
  );

  // Decouple front and back
  hsdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  // Probe the table and report
  hsdf_probe u_probe (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .status  (status),
    .results (results)
  );

endmodule

`default_nettype wire

### hw/rtl/hsdf_front.sv
// Front of the dedup filter: configuration registers, input accept, classification.
// Depends on hsdf_pkg and hsdf_in_if.
`default_nettype none

module hsdf_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  hsdf_in_if.sink                                items,
  input  wire logic                              cfg_we,
  input  wire logic [hsdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hsdf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire hsdf_pkg::status_t                 status,
  input  wire logic                              q_full,
  output logic                                   push,
  output hsdf_pkg::entry_t                       entry
);

  logic                                  report_repeated;
  logic [hsdf_pkg::INDEX_BITS_W-1:0]     index_bits;
  logic [hsdf_pkg::INDEX_BITS_W-1:0]     bits_eff;
  logic [hsdf_pkg::SLOT_W-1:0]           mask;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      report_repeated <= 1'b0;
      index_bits      <= hsdf_pkg::INDEX_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hsdf_pkg::CFG_REPORT_REPEATED: report_repeated <= cfg_data[0];
        hsdf_pkg::CFG_INDEX_BITS:      index_bits      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Build the index mask: at least four bits, at most the table width
  always_comb begin
    bits_eff = (index_bits < hsdf_pkg::INDEX_BITS_MIN) ? hsdf_pkg::INDEX_BITS_MIN
                                                        : index_bits;
    for (int i = 0; i < hsdf_pkg::SLOT_W; i++) begin
      mask[i] = (hsdf_pkg::INDEX_BITS_W'(i) < bits_eff);
    end
  end

  // Accept while the queue has room and the table is not being cleared
  assign items.ready = !q_full && !status.clearing;
  assign push        = items.valid && items.ready;

  always_comb begin
    entry.key_hash        = items.key_hash;
    entry.start_idx       = items.key_hash[hsdf_pkg::SLOT_W-1:0] & mask;
    entry.mask            = mask;
    entry.report_repeated = report_repeated;
  end

endmodule

`default_nettype wire

### hw/rtl/hsdf_queue.sv
// Short FIFO of classified items between the front and the prober.
// Depends on hsdf_pkg.
`default_nettype none

module hsdf_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hsdf_pkg::entry_t   push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    valid,
  output hsdf_pkg::entry_t        entry
);

  hsdf_pkg::entry_t                slots [hsdf_pkg::QUEUE_DEPTH];
  logic [hsdf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [hsdf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [hsdf_pkg::QCNT_W-1:0]     count;

  assign full  = (count == hsdf_pkg::QCNT_W'(hsdf_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign entry = slots[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hsdf_probe.sv
// Back of the dedup filter: slot table, linear probe sequencer, counters, result register.
// Depends on hsdf_pkg and hsdf_out_if.
`default_nettype none

module hsdf_probe (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire hsdf_pkg::entry_t   q_entry,
  output logic                    pop,
  output hsdf_pkg::status_t       status,
  hsdf_out_if.source              results
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROBE = 3'b100
  } state_t;

  state_t                                state;
  logic [hsdf_pkg::SLOT_W-1:0]           clr_addr;
  logic [hsdf_pkg::KEY_W-1:0]            cur_hash;
  logic [hsdf_pkg::SLOT_W-1:0]           cur_idx;
  logic [hsdf_pkg::SLOT_W-1:0]           cur_mask;
  logic                                  cur_rep;
  logic [hsdf_pkg::PROBE_CNT_W-1:0]      probe_cnt;
  logic [hsdf_pkg::UNIQUE_W-1:0]         unique_cnt;
  logic [hsdf_pkg::OVERFLOW_W-1:0]       ovf_cnt;

  logic [hsdf_pkg::KEY_W-1:0]            mem [hsdf_pkg::TABLE_SLOTS];
  logic [hsdf_pkg::KEY_W-1:0]            rd_data;

  logic                                  out_free;
  logic                                  hit_empty;
  logic                                  hit_match;
  logic                                  last_probe;
  logic                                  done;
  logic                                  finish;
  logic [hsdf_pkg::SLOT_W-1:0]           next_idx;
  logic                                  mem_re;
  logic                                  mem_we;
  logic [hsdf_pkg::SLOT_W-1:0]           mem_raddr;
  logic [hsdf_pkg::SLOT_W-1:0]           mem_waddr;
  logic [hsdf_pkg::KEY_W-1:0]            mem_wdata;
  hsdf_pkg::outcome_t                    outcome_next;
  logic [hsdf_pkg::UNIQUE_W-1:0]         unique_next;
  logic [hsdf_pkg::OVERFLOW_W-1:0]       ovf_next;

  // Decide the current probe step
  always_comb begin
    out_free   = !results.valid || results.ready;
    hit_empty  = (rd_data == '0);
    hit_match  = (rd_data == cur_hash);
    last_probe = (probe_cnt == hsdf_pkg::PROBE_CNT_W'(hsdf_pkg::PROBE_LIMIT - 1));
    done       = (state == ST_PROBE) && (hit_empty || hit_match || last_probe);
    finish     = done && out_free;
    next_idx   = (cur_idx + 1'b1) & cur_mask;
    pop        = (state == ST_IDLE) && q_valid;
    mem_re     = pop || ((state == ST_PROBE) && !done);
    mem_raddr  = pop ? q_entry.start_idx : next_idx;
    mem_we     = (state == ST_CLEAR) || (finish && hit_empty);
    mem_waddr  = (state == ST_CLEAR) ? clr_addr : cur_idx;
    mem_wdata  = (state == ST_CLEAR) ? '0 : cur_hash;

    // An empty slot wins over a match, so a zero key never reads as duplicate
    if (hit_empty) begin
      outcome_next = hsdf_pkg::OUT_NEW;
    end else if (hit_match) begin
      outcome_next = hsdf_pkg::OUT_DUP;
    end else begin
      outcome_next = hsdf_pkg::OUT_OVF;
    end

    unique_next = unique_cnt;
    ovf_next    = ovf_cnt;
    if (outcome_next == hsdf_pkg::OUT_NEW && unique_cnt != '1) begin
      unique_next = unique_cnt + 1'b1;
    end
    if (outcome_next == hsdf_pkg::OUT_OVF && ovf_cnt != '1) begin
      ovf_next = ovf_cnt + 1'b1;
    end
  end

  assign status.clearing = (state == ST_CLEAR);

  // Slot table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequence the clearing pass and the probes
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      unique_cnt <= '0;
      ovf_cnt    <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (finish) begin
            state      <= ST_IDLE;
            unique_cnt <= unique_next;
            ovf_cnt    <= ovf_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Load the item on pop, advance the index on each miss
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_hash  <= q_entry.key_hash;
      cur_idx   <= q_entry.start_idx;
      cur_mask  <= q_entry.mask;
      cur_rep   <= q_entry.report_repeated;
      probe_cnt <= '0;
    end else if ((state == ST_PROBE) && !done) begin
      cur_idx   <= next_idx;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (finish) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      results.outcome        <= outcome_next;
      results.emit           <= (!cur_rep && outcome_next == hsdf_pkg::OUT_NEW) ||
                                (cur_rep && outcome_next == hsdf_pkg::OUT_DUP);
      results.unique_total   <= unique_next;
      results.overflow_total <= ovf_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hsdf_checker.sv
// Port-level checker for the hash set dedup filter, bound to the top level.
// Depends on hsdf_pkg and the assertion macros header.
`default_nettype none

`include "hash_set_dedup_filter_defines.svh"

module hsdf_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_ready,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic [1:0]                          outcome,
  input  wire logic                                emit,
  input  wire logic [hsdf_pkg::UNIQUE_W-1:0]       unique_total,
  input  wire logic [hsdf_pkg::OVERFLOW_W-1:0]     overflow_total
);

  logic ovf_out;
  logic hit_out;

  // Classify the offered result
  assign ovf_out = out_valid && (outcome == hsdf_pkg::OUT_OVF);
  assign hit_out = out_valid && (outcome != hsdf_pkg::OUT_OVF);

  // Stalled result stays offered
  `HSDF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Table clearing blocks input right after reset
  `HSDF_ASSERT_ALWAYS(a_clear_blocks, $past(rst) |-> !in_ready, "input taken during clearing")

  // Overflow never passes and is always counted
  `HSDF_ASSERT(a_ovf_counted, ovf_out |-> !emit && overflow_total != '0, "bad overflow result")

  // New or duplicate implies something was stored
  `HSDF_ASSERT(a_hit_counted, hit_out |-> unique_total != '0, "hit with empty unique count")

endmodule

bind hash_set_dedup_filter hsdf_checker u_hsdf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (items.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .outcome        (results.outcome),
  .emit           (results.emit),
  .unique_total   (results.unique_total),
  .overflow_total (results.overflow_total)
);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for hash_set_dedup_filter: drives hash items, predicts each
// outcome with a software copy of the probe table, and checks every result.
// Depends on hsdf_pkg, hsdf_if and the RTL of hash_set_dedup_filter.
module testbench;
  import hsdf_pkg::*;

  localparam int LIMIT_CYCLES  = 20_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 50;
  localparam int SHORT_PROBE   = 40;
  localparam int POOL_DEPTH    = 512;

  typedef struct {
    logic [KEY_W-1:0]      key;
    outcome_t              outcome;
    logic                  emit;
    logic [UNIQUE_W-1:0]   unique_total;
    logic [OVERFLOW_W-1:0] overflow_total;
  } verdict_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hsdf_in_if  items_ch ();
  hsdf_out_if results_ch ();

  hash_set_dedup_filter dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: stored hashes, counters and register values
  bit [KEY_W-1:0]        slot_store [TABLE_SLOTS];
  bit [UNIQUE_W-1:0]     unique_count;
  bit [OVERFLOW_W-1:0]   spill_tally;
  bit                    repeat_mode = 1'b0;
  bit [INDEX_BITS_W-1:0] index_width = INDEX_BITS_RESET;

  verdict_t         verdicts_due [$];
  logic [KEY_W-1:0] key_pool [$];
  logic [SLOT_W-1:0] cluster_base;

  int error_count;
  int item_gap_max;
  int result_gap_max;
  int hold_cycles;
  int long_budget;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("testbench: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want, input logic [KEY_W-1:0] key);
    if (error_count < 100)
      $display("mismatch %s for key %h: got %0h, expected %0h", what, key, got, want);
    error_count++;
  endtask

  // Active probe mask: index bits clamped to [4, SLOT_W]
  function automatic logic [SLOT_W-1:0] slot_mask();
    int b;
    b = int'(index_width);
    if (b < INDEX_BITS_MIN) b = int'(INDEX_BITS_MIN);
    if (b > SLOT_W) b = SLOT_W;
    return SLOT_W'((64'd1 << b) - 64'd1);
  endfunction

  // Walk the table from the key's low bits; store on an empty slot when committing.
  // Returns the number of slots visited.
  function automatic int probe_table(input logic [KEY_W-1:0] key, input bit commit,
                                     output outcome_t found);
    logic [SLOT_W-1:0] mask;
    logic [SLOT_W-1:0] idx;
    int n;
    mask = slot_mask();
    found = OUT_OVF;
    for (n = 0; n < PROBE_LIMIT; n++) begin
      idx = (key[SLOT_W-1:0] + SLOT_W'(n)) & mask;
      if (slot_store[idx] == '0) begin
        if (commit) slot_store[idx] = key;
        found = OUT_NEW;
        return n + 1;
      end
      if (slot_store[idx] == key) begin
        found = OUT_DUP;
        return n + 1;
      end
    end
    return PROBE_LIMIT;
  endfunction

  // Pick a key: repeats, clustered low bits, zero, single-bit patterns and random values. Keep the
  // probe walk short, except for a limited number of long walks and overflows.
  function automatic logic [KEY_W-1:0] draw_key();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] best;
    int best_cost;
    int cost;
    int sel;
    int t;
    outcome_t found;
    best = '0;
    best_cost = PROBE_LIMIT + 1;
    for (t = 0; t < 24; t++) begin
      sel = $urandom_range(0, 99);
      k = {$urandom, $urandom};
      if (sel < 35 && key_pool.size() > 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (sel < 60)
        k[SLOT_W-1:0] = cluster_base + SLOT_W'($urandom_range(0, 11));
      else if (sel < 64)
        k = '0;
      else if (sel < 68)
        k = ~(64'd1 << $urandom_range(0, 63));
      else if (sel < 72)
        k = 64'd1 << $urandom_range(0, 63);
      cost = probe_table(k, 1'b0, found);
      if (cost <= SHORT_PROBE) return k;
      if (long_budget > 0 && $urandom_range(0, 7) == 0) begin
        long_budget--;
        return k;
      end
      if (cost < best_cost) begin
        best_cost = cost;
        best = k;
      end
    end
    return best;
  endfunction

  // Offer one key, wait for the transfer, then predict its result
  task automatic send_hash(input logic [KEY_W-1:0] key);
    int gap;
    outcome_t found;
    verdict_t v;
    gap = $urandom_range(0, item_gap_max);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid    <= 1'b1;
    items_ch.key_hash <= key;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    void'(probe_table(key, 1'b1, found));
    if (found == OUT_NEW && unique_count != '1) unique_count++;
    if (found == OUT_OVF && spill_tally != '1) spill_tally++;
    if (found == OUT_NEW && key != '0) begin
      if (key_pool.size() >= POOL_DEPTH) void'(key_pool.pop_front());
      key_pool.push_back(key);
    end
    v.key            = key;
    v.outcome        = found;
    v.emit           = repeat_mode ? (found == OUT_DUP) : (found == OUT_NEW);
    v.unique_total   = unique_count;
    v.overflow_total = spill_tally;
    verdicts_due.push_back(v);
  endtask

  // Drop valid and hold until every predicted result has been checked
  task automatic drain_results();
    items_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles; only called while idle
  task automatic write_settings(input logic [CFG_DATA_W-1:0] mode_data,
                                input logic [CFG_DATA_W-1:0] bits_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REPORT_REPEATED;
    cfg_data  <= mode_data;
    @(posedge clk);
    cfg_index <= CFG_INDEX_BITS;
    cfg_data  <= bits_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat_mode = mode_data[0];
    index_width = bits_data[INDEX_BITS_W-1:0];
  endtask

  // Result side: random stall per transfer, plus a long hold when requested
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_ch.valid && results_ch.ready)
        wait_left = $urandom_range(0, result_gap_max);
      if (hold_cycles > 0) begin
        hold_cycles--;
        results_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(results_ch.outcome), 64'd0, '0);
      end else begin
        want = verdicts_due.pop_front();
        if (results_ch.outcome !== want.outcome)
          report_mismatch("outcome", 64'(results_ch.outcome), 64'(want.outcome), want.key);
        if (results_ch.emit !== want.emit)
          report_mismatch("emit", 64'(results_ch.emit), 64'(want.emit), want.key);
        if (results_ch.unique_total !== want.unique_total)
          report_mismatch("unique_total", 64'(results_ch.unique_total),
                          64'(want.unique_total), want.key);
        if (results_ch.overflow_total !== want.overflow_total)
          report_mismatch("overflow_total", 64'(results_ch.overflow_total),
                          64'(want.overflow_total), want.key);
      end
    end
  end

  // Reset register values: zero keys, repeats, wrap at the top slot, collisions
  task automatic test_reset_defaults();
    item_gap_max   = 13;
    result_gap_max = 13;
    send_hash(64'h0);
    send_hash(64'h0);
    send_hash(64'hFFFF_FFFF_FFFF_FFFF);
    send_hash(64'hFFFF_FFFF_FFFF_FFFF);
    send_hash(64'hFFFF_FFFF_FFFE_FFFF);
    send_hash(64'h8000_0000_0000_0000);
    send_hash(64'h0000_0000_0000_0001);
    send_hash(64'h8000_0000_0000_0000);
    drain_results();
  endtask

  // Repeated mode passes duplicates only
  task automatic test_repeated_mode();
    write_settings(5'd1, 5'd16);
    send_hash(64'hFFFF_FFFF_FFFF_FFFF);
    send_hash(64'h0000_0000_0000_1234);
    send_hash(64'h0000_0000_0000_1234);
    drain_results();
  endtask

  // Clamp index bits to the 16-slot floor, fill it and run off the probe limit
  task automatic test_small_table();
    logic [KEY_W-1:0] spill_key;
    bit open;
    int f;
    item_gap_max   = 3;
    result_gap_max = 3;
    write_settings(5'd0, 5'd0);
    repeat (16) begin
      open = 1'b0;
      for (f = 0; f < 16; f++)
        if (slot_store[f] == '0) open = 1'b1;
      if (open) send_hash({$urandom, $urandom});
    end
    spill_key = {$urandom, $urandom};
    send_hash(spill_key);
    drain_results();
    write_settings(5'd1, 5'd4);
    send_hash(64'h0);
    send_hash(slot_store[9]);
    drain_results();
    // Widen past the table size: the spilled key now finds room
    write_settings(5'd0, 5'd31);
    send_hash(spill_key);
    drain_results();
  endtask

  // Hold the result side while items keep coming, then pause until empty
  task automatic test_backpressure();
    write_settings(5'd0, 5'd16);
    cluster_base   = SLOT_W'($urandom);
    item_gap_max   = 0;
    result_gap_max = 0;
    hold_cycles    = 400;
    repeat (12) send_hash(draw_key());
    drain_results();
  endtask

  // Random phases over register settings and idle patterns
  task automatic test_random_mix();
    int phase;
    int idle_pick;
    long_budget = 30;
    for (phase = 0; phase < 10; phase++) begin
      drain_results();
      write_settings(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)));
      idle_pick      = $urandom_range(0, 3);
      item_gap_max   = (idle_pick == 0) ? 0 : (idle_pick == 1) ? 3 : 13;
      idle_pick      = $urandom_range(0, 3);
      result_gap_max = (idle_pick == 0) ? 0 : (idle_pick == 1) ? 3 : 13;
      cluster_base   = ($urandom_range(0, 3) == 0) ? '1 - SLOT_W'(7) : SLOT_W'($urandom);
      repeat (60) send_hash(draw_key());
    end
  endtask

  initial begin : run
    rst               <= 1'b1;
    items_ch.valid    <= 1'b0;
    items_ch.key_hash <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_REPORT_REPEATED;
    cfg_data          <= '0;
    error_count    = 0;
    hold_cycles    = 0;
    long_budget    = 0;
    item_gap_max   = 0;
    result_gap_max = 0;
    cluster_base   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_repeated_mode();
    test_small_table();
    test_backpressure();
    test_random_mix();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/hsdf_pkg.sv
hw/rtl/hsdf_if.sv
hw/rtl/hsdf_front.sv
hw/rtl/hsdf_queue.sv
hw/rtl/hsdf_probe.sv
hw/rtl/hash_set_dedup_filter.sv
hw/rtl/hsdf_checker.sv
tb/sv/testbench.sv
